// ===== rtl/modexp_pkg.sv =====
// Package for the modular exponentiation block: widths, register indexes,
// controller states and the request/response types of the multiplier.
// Depends on nothing; every other file imports it.
package modexp_pkg;

  localparam int RES_W     = 31;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_CNT_W = $clog2(RES_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(1);

  typedef logic [RES_W-1:0] res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ROUND,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    res_t a;
    res_t b;
  } mm_req_t;

  typedef struct packed {
    logic done;
    res_t result;
  } mm_rsp_t;

endpackage

// ===== rtl/modexp_basered.sv =====
// Bit-serial reduction of the input base by the modulus, most significant bit first.
// Depends on modexp_pkg.
module modexp_basered #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DATA_WIDTH-1:0]   value,
  input  modexp_pkg::res_t        modulus,
  output logic                    done,
  output modexp_pkg::res_t        result
);
  import modexp_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] sh;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  res_t                  rem;
  logic [RES_W:0]        trial;
  logic [RES_W:0]        rem_next;

  always_comb begin
    trial = {rem, sh[DATA_WIDTH-1]};
    if (trial >= {1'b0, modulus}) begin
      rem_next = trial - {1'b0, modulus};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= value;
      rem <= '0;
      cnt <= CNT_W'(DATA_WIDTH);
    end else if (busy) begin
      sh  <= sh << 1;
      rem <= rem_next[RES_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign result = rem;

endmodule

// ===== rtl/modexp_mulmod.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, least significant first.
// Depends on modexp_pkg.
module modexp_mulmod (
  input  logic                 clk,
  input  logic                 rst,
  input  modexp_pkg::mm_req_t  req,
  input  modexp_pkg::res_t     modulus,
  output modexp_pkg::mm_rsp_t  rsp
);
  import modexp_pkg::*;

  res_t                 acc;
  res_t                 addend;
  res_t                 mult;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [RES_W:0]       sum_acc;
  logic [RES_W:0]       sum_dbl;
  res_t                 acc_next;
  res_t                 addend_next;

  always_comb begin
    sum_acc = {1'b0, acc} + {1'b0, addend};
    sum_dbl = {1'b0, addend} + {1'b0, addend};
    acc_next = acc;
    if (mult[0]) begin
      if (sum_acc >= {1'b0, modulus}) begin
        acc_next = RES_W'(sum_acc - {1'b0, modulus});
      end else begin
        acc_next = sum_acc[RES_W-1:0];
      end
    end
    if (sum_dbl >= {1'b0, modulus}) begin
      addend_next = RES_W'(sum_dbl - {1'b0, modulus});
    end else begin
      addend_next = sum_dbl[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == MUL_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == MUL_CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= '0;
      addend <= req.a;
      mult   <= req.b;
      cnt    <= MUL_CNT_W'(RES_W);
    end else if (busy) begin
      acc    <= acc_next;
      addend <= addend_next;
      mult   <= mult >> 1;
      cnt    <= cnt - MUL_CNT_W'(1);
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: registers, sequencer and output register.
// Depends on modexp_pkg, modexp_basered and modexp_mulmod.
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_valid/ready    cfg_index, cfg_data
//   in       in         in_valid/stall     base_value
//   out      out        out_valid/stall    power_residue
//
// An item first has its base reduced by the modulus, then goes through modular multiplications
// in the bit-serial multiplier, one square for every exponent bit below the highest set one
// and one further product for every set bit, and ends in a finish state that loads the result.
// The next item is taken only once that result has been loaded into the output register.
// Reset is synchronous and restores the modulus to 1 and the exponent to 0.
// A new item is taken while a finished result still waits on a stalled output.
module modular_exponentiation #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [modexp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [modexp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [DATA_WIDTH-1:0]               base_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output modexp_pkg::res_t                    power_residue
);
  import modexp_pkg::*;

  state_t  state;
  state_t  state_next;
  res_t    modulus;
  res_t    exponent;
  res_t    acc;
  res_t    sq;
  res_t    exp_sh;
  logic    red_start;
  logic    red_done;
  res_t    red_result;
  mm_req_t mm_req;
  mm_rsp_t mm_rsp;
  logic    out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= RES_W'(1);
      exponent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODULUS:  modulus  <= cfg_data[RES_W-1:0];
        CFG_EXPONENT: exponent <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  modexp_basered #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_basered (
    .clk    (clk),
    .rst    (rst),
    .start  (red_start),
    .value  (base_value),
    .modulus(modulus),
    .done   (red_done),
    .result (red_result)
  );

  modexp_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .req    (mm_req),
    .modulus(modulus),
    .rsp    (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    red_start    = 1'b0;
    mm_req.start = 1'b0;
    mm_req.a     = sq;
    mm_req.b     = sq;
    out_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          red_start  = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (exp_sh == '0) begin
          state_next = ST_FINISH;
        end else if (exp_sh[0]) begin
          mm_req.start = 1'b1;
          mm_req.a     = acc;
          state_next   = ST_MUL_ACC;
        end else begin
          mm_req.start = 1'b1;
          state_next   = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        if (mm_rsp.done) begin
          state_next = ST_ROUND;
        end
      end
      ST_MUL_SQ: begin
        if (mm_rsp.done) begin
          state_next = ST_ROUND;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (red_start) begin
      exp_sh <= exponent;
      acc    <= (modulus == RES_W'(1)) ? '0 : RES_W'(1);
    end
    if ((state == ST_REDUCE) && red_done) begin
      sq <= red_result;
    end
    if ((state == ST_MUL_ACC) && mm_rsp.done) begin
      acc       <= mm_rsp.result;
      exp_sh[0] <= 1'b0;
    end
    if ((state == ST_MUL_SQ) && mm_rsp.done) begin
      sq     <= mm_rsp.result;
      exp_sh <= exp_sh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A zero modulus lies outside the legal range and yields zero.
  always_ff @(posedge clk) begin
    if (out_load) begin
      power_residue <= (modulus == '0) ? '0 : acc;
    end
  end

endmodule
